// File: sv/cdlh_pkg.sv
package cdlh_pkg;

   // Default number of function slots.
   localparam int FUNC_SLOTS_DEF = 8;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_FRAME = 2'd1;
   localparam logic [1:0] OP_ARM   = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Result kinds on the response channel.
   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_KEY    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Function slot status codes.
   localparam logic [2:0] SLOT_IDLE    = 3'd0;
   localparam logic [2:0] SLOT_WAIT    = 3'd1;
   localparam logic [2:0] SLOT_DONE    = 3'd2;
   localparam logic [2:0] SLOT_PARTIAL = 3'd3;
   localparam logic [2:0] SLOT_ERROR   = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SYNC_TX_ID    = 3'd0;
   localparam logic [2:0] CSR_SYNC_REPLY_ID = 3'd1;
   localparam logic [2:0] CSR_KEYPRESS_ID   = 3'd2;
   localparam logic [2:0] CSR_REPLY_MASK    = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT       = 3'd4;
   localparam logic [2:0] CSR_KEY_HOLD_MASK = 3'd5;
   localparam logic [2:0] CSR_FILLER        = 3'd6;

   // Configuration reset values.
   localparam logic [10:0] SYNC_TX_ID_RST    = 11'd991;
   localparam logic [10:0] SYNC_REPLY_ID_RST = 11'd975;
   localparam logic [10:0] KEYPRESS_ID_RST   = 11'd169;
   localparam logic [10:0] REPLY_MASK_RST    = 11'd1024;
   localparam logic [6:0]  TIMEOUT_RST       = 7'd5;
   localparam logic [7:0]  KEY_HOLD_MASK_RST = 8'd128;
   localparam logic [7:0]  FILLER_RST        = 8'd129;

   // Protocol bytes.
   localparam logic [7:0] B_KEEPALIVE  = 8'h79;
   localparam logic [7:0] B_SYNC_REQ   = 8'h7A;
   localparam logic [7:0] B_SYNC_OK0   = 8'h61;
   localparam logic [7:0] B_SYNC_OK1   = 8'h11;
   localparam logic [7:0] B_SYNC_SUB   = 8'h1A;
   localparam logic [7:0] B_SYNC_ACK0  = 8'h70;
   localparam logic [7:0] B_ALIVE      = 8'h69;
   localparam logic [7:0] B_ACK        = 8'h74;
   localparam logic [7:0] B_PARTIAL0   = 8'h30;
   localparam logic [7:0] B_KEY0       = 8'h03;
   localparam logic [7:0] B_KEY1       = 8'h89;
   localparam logic [7:0] B_SYNC_FILL  = 8'h81;
   localparam logic [7:0] B_ONE        = 8'h01;
   localparam logic [7:0] B_ZERO       = 8'h00;
   localparam logic [15:0] KEY_PLAIN_A = 16'h0101;
   localparam logic [15:0] KEY_PLAIN_B = 16'h0141;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_RD_WAIT,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   // Class of the captured request.
   typedef enum logic [2:0] {
      CLS_TICK,
      CLS_SYNC_ACK,
      CLS_REPLY,
      CLS_KEY,
      CLS_ACK,
      CLS_DROP,
      CLS_ARM,
      CLS_READ
   } cls_type;

   // Result selected into the output register.
   typedef enum logic [2:0] {
      RES_KEEPALIVE,
      RES_SYNC_REQ,
      RES_SYNC_ACK,
      RES_KEY,
      RES_ACK,
      RES_STATUS
   } res_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    capture;
      logic    exec;
      logic    rd_en;
      logic    rd_search;
      logic    idx_inc;
      logic    settle;
      logic    stat_load;
      logic    load_out;
      res_type res_sel;
      logic    out_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cls_type cls;
      logic    second;
      logic    out_free;
      logic    in_range;
      logic    slot_hit;
      logic    idx_last;
   } sts_type;

endpackage

// File: sv/cdlh_ctrl.sv
module cdlh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cdlh_pkg::sts_type sts,
   output cdlh_pkg::cmd_type cmd
);

   cdlh_pkg::state_type state_ff;
   cdlh_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdlh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdlh_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = cdlh_pkg::ST_DECODE;
         end
         cdlh_pkg::ST_DECODE: begin
            unique case (sts.cls)
               cdlh_pkg::CLS_REPLY: state_in = cdlh_pkg::ST_SRCH_RD;
               cdlh_pkg::CLS_DROP:  state_in = cdlh_pkg::ST_IDLE;
               cdlh_pkg::CLS_READ: begin
                  state_in = sts.in_range ? cdlh_pkg::ST_RD_WAIT : cdlh_pkg::ST_EMIT_A;
               end
               default: state_in = cdlh_pkg::ST_EMIT_A;
            endcase
         end
         cdlh_pkg::ST_SRCH_RD: begin
            state_in = cdlh_pkg::ST_SRCH_CMP;
         end
         cdlh_pkg::ST_SRCH_CMP: begin
            if (sts.slot_hit || sts.idx_last) state_in = cdlh_pkg::ST_IDLE;
            else state_in = cdlh_pkg::ST_SRCH_RD;
         end
         cdlh_pkg::ST_RD_WAIT: begin
            state_in = cdlh_pkg::ST_EMIT_A;
         end
         cdlh_pkg::ST_EMIT_A: begin
            if (sts.out_free) begin
               if (sts.cls == cdlh_pkg::CLS_TICK && sts.second) begin
                  state_in = cdlh_pkg::ST_EMIT_B;
               end else begin
                  state_in = cdlh_pkg::ST_IDLE;
               end
            end
         end
         cdlh_pkg::ST_EMIT_B: begin
            if (sts.out_free) state_in = cdlh_pkg::ST_IDLE;
         end
         default: state_in = cdlh_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      cmd.res_sel = cdlh_pkg::RES_STATUS;
      req_tready = 1'b0;
      unique case (state_ff)
         cdlh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         cdlh_pkg::ST_DECODE: begin
            cmd.exec = 1'b1;
            cmd.rd_en = (sts.cls == cdlh_pkg::CLS_READ) && sts.in_range;
         end
         cdlh_pkg::ST_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_search = 1'b1;
         end
         cdlh_pkg::ST_SRCH_CMP: begin
            cmd.settle = sts.slot_hit;
            cmd.idx_inc = !sts.slot_hit && !sts.idx_last;
         end
         cdlh_pkg::ST_RD_WAIT: begin
            cmd.stat_load = 1'b1;
         end
         cdlh_pkg::ST_EMIT_A: begin
            cmd.load_out = sts.out_free;
            cmd.out_last = !(sts.cls == cdlh_pkg::CLS_TICK && sts.second);
            unique case (sts.cls)
               cdlh_pkg::CLS_TICK:     cmd.res_sel = cdlh_pkg::RES_KEEPALIVE;
               cdlh_pkg::CLS_SYNC_ACK: cmd.res_sel = cdlh_pkg::RES_SYNC_ACK;
               cdlh_pkg::CLS_KEY:      cmd.res_sel = cdlh_pkg::RES_KEY;
               cdlh_pkg::CLS_ACK:      cmd.res_sel = cdlh_pkg::RES_ACK;
               default:                cmd.res_sel = cdlh_pkg::RES_STATUS;
            endcase
         end
         cdlh_pkg::ST_EMIT_B: begin
            cmd.load_out = sts.out_free;
            cmd.out_last = 1'b1;
            cmd.res_sel = cdlh_pkg::RES_SYNC_REQ;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // The output register is never loaded while it still holds an untaken result.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("output register loaded while occupied");

   // An accepted transaction is decoded in the following cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdlh_pkg::ST_IDLE) && req_tvalid |=> state_ff == cdlh_pkg::ST_DECODE)
      else $error("accepted transaction not decoded");

   // The sync request is only sent by a tick that asked for one.
   a_second_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdlh_pkg::ST_EMIT_B) |-> sts.second && sts.cls == cdlh_pkg::CLS_TICK)
      else $error("second frame without sync request");

endmodule

// File: sv/cdlh_datapath.sv
module cdlh_datapath #(
   parameter int FUNC_SLOTS = cdlh_pkg::FUNC_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [47:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [10:0]       csr_wdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  cdlh_pkg::cmd_type cmd,
   output cdlh_pkg::sts_type sts
);

   localparam int SLOT_AW = (FUNC_SLOTS > 1) ? $clog2(FUNC_SLOTS) : 1;
   localparam logic [SLOT_AW-1:0] IDX_LAST = SLOT_AW'(FUNC_SLOTS - 1);

   // Configuration registers.
   logic [10:0] sync_tx_id_ff;
   logic [10:0] sync_reply_id_ff;
   logic [10:0] keypress_id_ff;
   logic [10:0] reply_mask_ff;
   logic [6:0]  timeout_ticks_ff;
   logic [7:0]  key_hold_mask_ff;
   logic [7:0]  filler_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_tx_id_ff    <= cdlh_pkg::SYNC_TX_ID_RST;
         sync_reply_id_ff <= cdlh_pkg::SYNC_REPLY_ID_RST;
         keypress_id_ff   <= cdlh_pkg::KEYPRESS_ID_RST;
         reply_mask_ff    <= cdlh_pkg::REPLY_MASK_RST;
         timeout_ticks_ff <= cdlh_pkg::TIMEOUT_RST;
         key_hold_mask_ff <= cdlh_pkg::KEY_HOLD_MASK_RST;
         filler_ff        <= cdlh_pkg::FILLER_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            cdlh_pkg::CSR_SYNC_TX_ID:    sync_tx_id_ff    <= csr_wdata;
            cdlh_pkg::CSR_SYNC_REPLY_ID: sync_reply_id_ff <= csr_wdata;
            cdlh_pkg::CSR_KEYPRESS_ID:   keypress_id_ff   <= csr_wdata;
            cdlh_pkg::CSR_REPLY_MASK:    reply_mask_ff    <= csr_wdata;
            cdlh_pkg::CSR_TIMEOUT:       timeout_ticks_ff <= csr_wdata[6:0];
            cdlh_pkg::CSR_KEY_HOLD_MASK: key_hold_mask_ff <= csr_wdata[7:0];
            cdlh_pkg::CSR_FILLER:        filler_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Captured request fields.
   logic [1:0]  op_ff;
   logic [10:0] id_ff;
   logic [7:0]  b0_ff, b1_ff, b2_ff, b3_ff;
   logic [2:0]  slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tuser;
         id_ff   <= req_tdata[10:0];
         b0_ff   <= req_tdata[18:11];
         b1_ff   <= req_tdata[26:19];
         b2_ff   <= req_tdata[34:27];
         b3_ff   <= req_tdata[42:35];
         slot_ff <= req_tdata[45:43];
      end
   end

   // Classify the captured transaction.
   logic    is_sync;
   logic    sync_ok;
   logic    key_hdr;
   cdlh_pkg::cls_type cls;

   assign is_sync = (id_ff == sync_reply_id_ff);
   assign sync_ok = (b0_ff == cdlh_pkg::B_SYNC_OK0) && (b1_ff == cdlh_pkg::B_SYNC_OK1);
   assign key_hdr = (b0_ff == cdlh_pkg::B_KEY0) && (b1_ff == cdlh_pkg::B_KEY1);

   always_comb begin
      priority if (op_ff == cdlh_pkg::OP_TICK) begin
         cls = cdlh_pkg::CLS_TICK;
      end else if (op_ff == cdlh_pkg::OP_FRAME) begin
         priority if (is_sync) begin
            priority if (sync_ok) cls = cdlh_pkg::CLS_SYNC_ACK;
            else if (b0_ff == cdlh_pkg::B_ALIVE) cls = cdlh_pkg::CLS_TICK;
            else cls = cdlh_pkg::CLS_DROP;
         end else if ((id_ff & reply_mask_ff) != 11'd0) begin
            cls = cdlh_pkg::CLS_REPLY;
         end else if (id_ff == keypress_id_ff) begin
            cls = key_hdr ? cdlh_pkg::CLS_KEY : cdlh_pkg::CLS_DROP;
         end else begin
            cls = cdlh_pkg::CLS_ACK;
         end
      end else if (op_ff == cdlh_pkg::OP_ARM) begin
         cls = cdlh_pkg::CLS_ARM;
      end else begin
         cls = cdlh_pkg::CLS_READ;
      end
   end

   // Link state: sync flags and timeout count.
   logic       failed_ff, failed_in;
   logic       start_ff, start_in;
   logic       alive_ff, alive_in;
   logic [7:0] timeout_ff, timeout_in;
   logic       second_ff, second_in;
   logic       alive_now;
   logic [7:0] timeout_dec;

   assign alive_now   = alive_ff || (op_ff == cdlh_pkg::OP_FRAME);
   assign timeout_dec = timeout_ff - 8'd1;

   always_comb begin
      failed_in  = failed_ff;
      start_in   = start_ff;
      alive_in   = alive_ff;
      timeout_in = timeout_ff;
      second_in  = second_ff;
      if (cmd.exec && cls == cdlh_pkg::CLS_TICK) begin
         second_in = failed_ff || start_ff;
         priority if (failed_ff || start_ff) begin
            start_in = 1'b0;
            alive_in = alive_now;
         end else if (alive_now) begin
            timeout_in = {1'b0, timeout_ticks_ff};
            alive_in   = 1'b0;
         end else begin
            timeout_in = timeout_dec;
            alive_in   = 1'b0;
            if (timeout_dec == 8'd0 || timeout_dec[7]) begin
               failed_in = 1'b1;
               start_in  = 1'b0;
            end
         end
      end else if (cmd.exec && cls == cdlh_pkg::CLS_SYNC_ACK) begin
         failed_in = 1'b0;
         if (b2_ff == cdlh_pkg::B_ONE) start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff  <= 1'b0;
         start_ff   <= 1'b1;
         alive_ff   <= 1'b0;
         timeout_ff <= {1'b0, cdlh_pkg::TIMEOUT_RST};
         second_ff  <= 1'b0;
      end else begin
         failed_ff  <= failed_in;
         start_ff   <= start_in;
         alive_ff   <= alive_in;
         timeout_ff <= timeout_in;
         second_ff  <= second_in;
      end
   end

   // Function slot memory with one valid bit per entry.
   logic [10:0]        func_mem [FUNC_SLOTS];
   logic [2:0]         state_mem [FUNC_SLOTS];
   logic [FUNC_SLOTS-1:0] slot_valid_ff;
   logic [SLOT_AW-1:0] idx_ff;
   logic [SLOT_AW-1:0] slot_addr;
   logic [SLOT_AW-1:0] rd_addr;
   logic [SLOT_AW-1:0] wr_addr;
   logic               in_range;
   logic               arm_we;
   logic               settle_we;
   logic [10:0]        func_q;
   logic [2:0]         state_q;
   logic               valid_q;
   logic [10:0]        func_eff;
   logic [2:0]         state_eff;
   logic [10:0]        fid;
   logic [2:0]         settle_val;

   assign in_range  = 32'(slot_ff) < FUNC_SLOTS;
   assign slot_addr = SLOT_AW'(32'(slot_ff));
   assign rd_addr   = cmd.rd_search ? idx_ff : slot_addr;
   assign arm_we    = cmd.exec && (cls == cdlh_pkg::CLS_ARM) && in_range;
   assign func_eff  = valid_q ? func_q : 11'd0;
   assign state_eff = valid_q ? state_q : cdlh_pkg::SLOT_IDLE;
   assign fid       = id_ff & ~reply_mask_ff;
   assign settle_we = cmd.settle && (state_eff == cdlh_pkg::SLOT_WAIT);
   assign wr_addr   = cmd.settle ? idx_ff : slot_addr;

   // Settled state from the reply payload.
   always_comb begin
      priority if (b0_ff == cdlh_pkg::B_ACK) begin
         settle_val = cdlh_pkg::SLOT_DONE;
      end else if (b0_ff == cdlh_pkg::B_PARTIAL0 && b1_ff == cdlh_pkg::B_ONE &&
                   b2_ff == cdlh_pkg::B_ZERO) begin
         settle_val = cdlh_pkg::SLOT_PARTIAL;
      end else begin
         settle_val = cdlh_pkg::SLOT_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (arm_we) func_mem[wr_addr] <= id_ff;
      if (arm_we || settle_we) begin
         state_mem[wr_addr] <= arm_we ? cdlh_pkg::SLOT_WAIT : settle_val;
      end
      if (cmd.rd_en) begin
         func_q  <= func_mem[rd_addr];
         state_q <= state_mem[rd_addr];
         valid_q <= slot_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (arm_we) begin
         slot_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Search index over the slots.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.exec) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + SLOT_AW'(1);
      end
   end

   // Reported slot status.
   logic [2:0] stat_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         stat_ff <= arm_we ? cdlh_pkg::SLOT_WAIT : cdlh_pkg::SLOT_IDLE;
      end else if (cmd.stat_load) begin
         stat_ff <= state_eff;
      end
   end

   // Result assembly.
   logic [1:0]  r_kind;
   logic [10:0] r_id;
   logic [63:0] r_payload;
   logic [15:0] r_key;
   logic        r_hold;
   logic [2:0]  r_stat;
   logic [15:0] key_raw;
   logic        key_plain;

   assign key_raw   = {b2_ff, b3_ff};
   assign key_plain = (key_raw == cdlh_pkg::KEY_PLAIN_A) || (key_raw == cdlh_pkg::KEY_PLAIN_B);

   always_comb begin
      r_kind    = cdlh_pkg::KIND_FRAME;
      r_id      = 11'd0;
      r_payload = 64'd0;
      r_key     = 16'd0;
      r_hold    = 1'b0;
      r_stat    = cdlh_pkg::SLOT_IDLE;
      unique case (cmd.res_sel)
         cdlh_pkg::RES_KEEPALIVE: begin
            r_id      = sync_tx_id_ff;
            r_payload = {{6{filler_ff}}, cdlh_pkg::B_ZERO, cdlh_pkg::B_KEEPALIVE};
         end
         cdlh_pkg::RES_SYNC_REQ: begin
            r_id      = sync_tx_id_ff;
            r_payload = {{6{cdlh_pkg::B_SYNC_FILL}}, cdlh_pkg::B_ONE, cdlh_pkg::B_SYNC_REQ};
         end
         cdlh_pkg::RES_SYNC_ACK: begin
            r_id      = sync_tx_id_ff;
            r_payload = {cdlh_pkg::B_ONE, {4{cdlh_pkg::B_ZERO}}, cdlh_pkg::B_SYNC_OK1,
                         cdlh_pkg::B_SYNC_SUB, cdlh_pkg::B_SYNC_ACK0};
         end
         cdlh_pkg::RES_KEY: begin
            r_kind = cdlh_pkg::KIND_KEY;
            if (key_plain) begin
               r_key = key_raw;
            end else begin
               r_key  = key_raw & {8'hFF, ~key_hold_mask_ff};
               r_hold = |(b3_ff & key_hold_mask_ff);
            end
         end
         cdlh_pkg::RES_ACK: begin
            r_id      = id_ff | reply_mask_ff;
            r_payload = {{7{filler_ff}}, cdlh_pkg::B_ACK};
         end
         cdlh_pkg::RES_STATUS: begin
            r_kind = cdlh_pkg::KIND_STATUS;
            r_stat = stat_ff;
         end
         default: ;
      endcase
   end

   // Output register.
   logic        out_valid_ff;
   logic [95:0] out_data_ff;
   logic [1:0]  out_kind_ff;
   logic        out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= {failed_ff, r_stat, r_hold, r_key, r_payload, r_id};
         out_kind_ff <= r_kind;
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // Status to the controller.
   assign sts.cls      = cls;
   assign sts.second   = second_ff;
   assign sts.out_free = !out_valid_ff || rsp_tready;
   assign sts.in_range = in_range;
   assign sts.slot_hit = (func_eff == fid);
   assign sts.idx_last = (idx_ff == IDX_LAST);

   // A failed sync never leaves a restart pending.
   a_fail_clears_start: assert property (@(posedge clock) disable iff (reset)
      !failed_ff && failed_in |=> !start_ff)
      else $error("sync failure left start flag set");

   // Only an armed slot is ever settled.
   a_settle_valid: assert property (@(posedge clock) disable iff (reset)
      settle_we |-> valid_q && slot_valid_ff[idx_ff])
      else $error("settle on a slot never armed");

   // Arming and settling never write the slot memory together.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(arm_we && cmd.settle))
      else $error("two slot writes in one cycle");

endmodule

// File: sv/can_display_link_handler_core.sv
// CAN display link handler. Requests are tick, received frame, arm slot and read slot
// transactions; each yields zero, one or two results (frames to send, key events, slot
// status) on the response channel, with tlast on the final one. One request is handled
// at a time: it is accepted in the idle state, decoded in the next, and each result is
// loaded into the output register when that register is free; a slot read first passes
// through the registered slot memory. A reply-flagged frame walks the function slots
// through the slot memory, with a read state and a compare state per slot, until the
// first matching slot or the last slot. The output register lets a new request be accepted
// while the last result still waits. Configuration is written through csr_we/csr_addr/
// csr_wdata while idle; this is up to the user, as the core itself does not enforce it.
module can_display_link_handler_core #(
   parameter int FUNC_SLOTS = cdlh_pkg::FUNC_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // frame_id, rx_byte0, rx_byte1, rx_byte2, rx_byte3, slot
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // tx_id, tx_payload, key_code, key_hold, slot_status,
                                    // sync_failed
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [10:0] csr_wdata
);

   cdlh_pkg::cmd_type cmd;
   cdlh_pkg::sts_type sts;

   // Sequencing of each transaction.
   cdlh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Link state, slot memory and result assembly.
   cdlh_datapath #(
      .FUNC_SLOTS (FUNC_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: tb/can_display_link_handler_core_test.sv
`timescale 1ns / 1ps

module can_display_link_handler_core_test;
   import cdlh_pkg::*;

   // One request transaction as the driver sees it.
   typedef struct {
      logic [1:0]  op;
      logic [10:0] frame_id;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [2:0]  slot;
   } link_req_t;

   // One response transaction, field by field.
   typedef struct {
      logic [1:0]  kind;
      logic [10:0] tx_id;
      logic [63:0] payload;
      logic [15:0] key_code;
      logic        key_hold;
      logic [2:0]  slot_status;
      logic        sync_failed;
      logic        last;
   } link_result_t;

   // Register settings of the link.
   typedef struct {
      logic [10:0] tx_id;
      logic [10:0] reply_id;
      logic [10:0] key_id;
      logic [10:0] mask;
      logic [6:0]  timeout;
      logic [7:0]  hold_mask;
      logic [7:0]  filler;
   } link_cfg_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // frame_id, rx_byte0, rx_byte1, rx_byte2, rx_byte3, slot
   logic [1:0]  req_tuser = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // tx_id, tx_payload, key_code, key_hold, slot_status,
                                  // sync_failed
   logic [1:0]  rsp_tuser;        // kind
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [10:0] csr_wdata = '0;

   // Stimulus and expectation stores.
   link_req_t    pending_q[$];
   link_result_t step_q[$];
   link_result_t awaited_q[$];
   link_req_t    drv_item;

   // Shadow of the link state and its settings.
   link_cfg_t   cfg;
   logic        m_failed;
   logic        m_start;
   logic        m_alive;
   logic [7:0]  m_count;
   logic [10:0] m_slot_fid[FUNC_SLOTS_DEF];
   logic [2:0]  m_slot_state[FUNC_SLOTS_DEF];

   logic        req_fire = 1'b0;
   logic        quiet_phase = 1'b0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          fail_count = 0;

   can_display_link_handler_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic link_result_t make_result(input logic [1:0] kind,
                                                input logic [10:0] id,
                                                input logic [63:0] pl,
                                                input logic [15:0] key,
                                                input logic hold,
                                                input logic [2:0] stat);
      link_result_t r;
      r.kind        = kind;
      r.tx_id       = id;
      r.payload     = pl;
      r.key_code    = key;
      r.key_hold    = hold;
      r.slot_status = stat;
      r.sync_failed = 1'b0;
      r.last        = 1'b0;
      return r;
   endfunction

   // Keepalive, then either a sync request or the timeout bookkeeping.
   task automatic run_tick();
      step_q.push_back(make_result(KIND_FRAME, cfg.tx_id,
                                   {{6{cfg.filler}}, B_ZERO, B_KEEPALIVE}, '0, 1'b0, '0));
      if (m_failed || m_start) begin
         step_q.push_back(make_result(KIND_FRAME, cfg.tx_id,
                                      {{6{B_SYNC_FILL}}, B_ONE, B_SYNC_REQ}, '0, 1'b0, '0));
         m_start = 1'b0;
      end else if (m_alive) begin
         m_count = {1'b0, cfg.timeout};
         m_alive = 1'b0;
      end else begin
         // The count wraps; zero or a negative value means the peer is gone.
         m_count = m_count - 8'd1;
         if (m_count == 8'd0 || m_count[7]) begin
            m_failed = 1'b1;
            m_start  = 1'b0;
            m_alive  = 1'b0;
         end
      end
   endtask

   // Works out the responses of one accepted request and queues them.
   task automatic predict_request(input link_req_t q);
      logic [10:0] fid;
      logic [15:0] raw;
      logic [2:0]  stat;
      int          hit;
      int          i;
      step_q.delete();
      case (q.op)
         OP_TICK: begin
            run_tick();
         end
         OP_FRAME: begin
            if (q.frame_id == cfg.reply_id) begin
               if (q.b0 == B_SYNC_OK0 && q.b1 == B_SYNC_OK1) begin
                  step_q.push_back(make_result(KIND_FRAME, cfg.tx_id,
                     {B_ONE, {4{B_ZERO}}, B_SYNC_OK1, B_SYNC_SUB, B_SYNC_ACK0},
                     '0, 1'b0, '0));
                  m_failed = 1'b0;
                  if (q.b2 == B_ONE) m_start = 1'b1;
               end else if (q.b0 == B_ALIVE) begin
                  m_alive = 1'b1;
                  run_tick();
               end
            end else if ((q.frame_id & cfg.mask) != '0) begin
               // Only the first slot holding the identifier may be settled.
               fid = q.frame_id & ~cfg.mask;
               hit = -1;
               for (i = FUNC_SLOTS_DEF - 1; i >= 0; i--) begin
                  if (m_slot_fid[i] == fid) hit = i;
               end
               if (hit >= 0 && m_slot_state[hit] == SLOT_WAIT) begin
                  if (q.b0 == B_ACK)
                     m_slot_state[hit] = SLOT_DONE;
                  else if (q.b0 == B_PARTIAL0 && q.b1 == B_ONE && q.b2 == B_ZERO)
                     m_slot_state[hit] = SLOT_PARTIAL;
                  else
                     m_slot_state[hit] = SLOT_ERROR;
               end
            end else if (q.frame_id == cfg.key_id) begin
               if (q.b0 == B_KEY0 && q.b1 == B_KEY1) begin
                  raw = {q.b2, q.b3};
                  if (raw == KEY_PLAIN_A || raw == KEY_PLAIN_B)
                     step_q.push_back(make_result(KIND_KEY, '0, '0, raw, 1'b0, '0));
                  else
                     step_q.push_back(make_result(KIND_KEY, '0, '0,
                                                  raw & ~{8'h00, cfg.hold_mask},
                                                  |(q.b3 & cfg.hold_mask), '0));
               end
            end else begin
               step_q.push_back(make_result(KIND_FRAME, q.frame_id | cfg.mask,
                                            {{7{cfg.filler}}, B_ACK}, '0, 1'b0, '0));
            end
         end
         OP_ARM, OP_READ: begin
            stat = SLOT_IDLE;
            if (q.slot < FUNC_SLOTS_DEF) begin
               if (q.op == OP_ARM) begin
                  m_slot_fid[q.slot]   = q.frame_id;
                  m_slot_state[q.slot] = SLOT_WAIT;
               end
               stat = m_slot_state[q.slot];
            end
            step_q.push_back(make_result(KIND_STATUS, '0, '0, '0, 1'b0, stat));
         end
      endcase
      for (i = 0; i < step_q.size(); i++) begin
         step_q[i].sync_failed = m_failed;
         step_q[i].last        = (i == step_q.size() - 1);
         awaited_q.push_back(step_q[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Request driver: one transaction per handshake, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // Hold the current transaction until it is taken.
      end else if (req_gap != 0) begin
         req_gap = req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (!quiet_phase && pending_q.size() != 0 && $urandom_range(0, 7) == 0) begin
         req_gap = $urandom_range(0, 6);
         req_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
         drv_item = pending_q.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {2'b00, drv_item.slot, drv_item.b3, drv_item.b2, drv_item.b1,
                        drv_item.b0, drv_item.frame_id};
         req_tuser  <= drv_item.op;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response sink: stalls come in bursts.
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: checks each response and predicts each accepted request.
   always @(posedge clock) begin
      link_result_t want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual kind %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("tx_id", want.tx_id, rsp_tdata[10:0]);
               check_field("tx_payload", want.payload, rsp_tdata[74:11]);
               check_field("key_code", want.key_code, rsp_tdata[90:75]);
               check_field("key_hold", want.key_hold, rsp_tdata[91]);
               check_field("slot_status", want.slot_status, rsp_tdata[94:92]);
               check_field("sync_failed", want.sync_failed, rsp_tdata[95]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_fire) predict_request(drv_item);
      end
   end

   task automatic queue_req(input logic [1:0] op, input logic [10:0] id,
                            input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [2:0] slot);
      link_req_t q;
      q.op       = op;
      q.frame_id = id;
      q.b0       = b0;
      q.b1       = b1;
      q.b2       = b2;
      q.b3       = b3;
      q.slot     = slot;
      pending_q.push_back(q);
   endtask

   // Waits until every transaction is out, then lets slot searches finish.
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || awaited_q.size() != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [10:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
   endtask

   // Fails the run if it hangs.
   initial begin
      #2_000_000;
      $display("can_display_link_handler_core verification failed");
      $finish;
   end

   initial begin
      link_req_t   q;
      link_cfg_t   c;
      logic [10:0] fid_pool[4];
      int          w;
      int          n;
      int          phase;
      int          i;

      // State after reset.
      cfg.tx_id     = SYNC_TX_ID_RST;
      cfg.reply_id  = SYNC_REPLY_ID_RST;
      cfg.key_id    = KEYPRESS_ID_RST;
      cfg.mask      = REPLY_MASK_RST;
      cfg.timeout   = TIMEOUT_RST;
      cfg.hold_mask = KEY_HOLD_MASK_RST;
      cfg.filler    = FILLER_RST;
      m_failed = 1'b0;
      m_start  = 1'b1;
      m_alive  = 1'b0;
      m_count  = {1'b0, TIMEOUT_RST};
      for (i = 0; i < FUNC_SLOTS_DEF; i++) begin
         m_slot_fid[i]   = '0;
         m_slot_state[i] = SLOT_IDLE;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings.
      queue_req(OP_TICK, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
      queue_req(OP_TICK, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
      // Sync reply that asks for a restart, then the tick that serves it.
      queue_req(OP_FRAME, cfg.reply_id, B_SYNC_OK0, B_SYNC_OK1, B_ONE, 8'hFF, 3'd0);
      queue_req(OP_TICK, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
      // Peer alive reply runs a tick that reloads the count.
      queue_req(OP_FRAME, cfg.reply_id, B_ALIVE, 8'h00, 8'h00, 8'h00, 3'd0);
      // Sync reply with other content is dropped, then a sync reply without a restart.
      queue_req(OP_FRAME, cfg.reply_id, 8'h12, 8'h34, 8'h56, 8'h78, 3'd0);
      queue_req(OP_FRAME, cfg.reply_id, B_SYNC_OK0, B_SYNC_OK1, B_ZERO, 8'h00, 3'd0);
      // Arm slots, then settle them as done, partial and error.
      queue_req(OP_ARM, 11'h123, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
      queue_req(OP_ARM, 11'h3FF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7);
      queue_req(OP_ARM, 11'h055, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3);
      queue_req(OP_ARM, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5);
      queue_req(OP_FRAME, 11'h523, B_ACK, 8'h00, 8'h00, 8'h00, 3'd0);
      queue_req(OP_FRAME, 11'h7FF, B_PARTIAL0, B_ONE, B_ZERO, 8'h00, 3'd0);
      queue_req(OP_FRAME, 11'h455, B_PARTIAL0, B_ONE, B_ONE, 8'h00, 3'd0);
      // An idle slot that holds the identifier first hides the waiting one.
      queue_req(OP_FRAME, 11'h400, B_ACK, 8'h00, 8'h00, 8'h00, 3'd0);
      queue_req(OP_READ, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
      queue_req(OP_READ, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7);
      queue_req(OP_READ, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3);
      queue_req(OP_READ, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5);
      // Key frames: the two plain codes, a held key and a bad header.
      queue_req(OP_FRAME, cfg.key_id, B_KEY0, B_KEY1, 8'h01, 8'h01, 3'd0);
      queue_req(OP_FRAME, cfg.key_id, B_KEY0, B_KEY1, 8'h01, 8'h41, 3'd0);
      queue_req(OP_FRAME, cfg.key_id, B_KEY0, B_KEY1, 8'hFF, 8'hFF, 3'd0);
      queue_req(OP_FRAME, cfg.key_id, B_KEY0, 8'h88, 8'h12, 8'h34, 3'd0);
      // Any other frame is acknowledged.
      queue_req(OP_FRAME, 11'h3FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0);
      queue_req(OP_TICK, 11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);

      // Random phases, each under its own settings.
      for (phase = 1; phase <= 5; phase++) begin
         wait_idle();
         case (phase)
            1: begin
               c.tx_id = 11'h7FF;  c.reply_id = 11'h000; c.key_id = 11'h155;
               c.mask = 11'h400;   c.timeout = 7'd1;     c.hold_mask = 8'hFF;
               c.filler = 8'h00;
            end
            2: begin
               c.tx_id = 11'h000;  c.reply_id = 11'h7FF; c.key_id = 11'h000;
               c.mask = 11'h000;   c.timeout = 7'd127;   c.hold_mask = 8'h00;
               c.filler = 8'hFF;
            end
            default: begin
               c.mask      = (phase == 5) ? $urandom : (11'd1 << $urandom_range(0, 10));
               c.tx_id     = $urandom;
               c.reply_id  = $urandom;
               c.key_id    = $urandom & ~c.mask;
               c.timeout   = $urandom_range(2, 8);
               c.hold_mask = (phase == 5) ? $urandom : (8'd1 << $urandom_range(0, 7));
               c.filler    = $urandom;
            end
         endcase
         write_csr(CSR_SYNC_TX_ID, c.tx_id);
         write_csr(CSR_SYNC_REPLY_ID, c.reply_id);
         write_csr(CSR_KEYPRESS_ID, c.key_id);
         write_csr(CSR_REPLY_MASK, c.mask);
         write_csr(CSR_TIMEOUT, {4'b0000, c.timeout});
         write_csr(CSR_KEY_HOLD_MASK, {3'b000, c.hold_mask});
         write_csr(CSR_FILLER, {3'b000, c.filler});
         @(negedge clock);
         csr_we <= 1'b0;
         cfg = c;
         for (i = 0; i < 4; i++) fid_pool[i] = $urandom & ~c.mask;
         if (phase == 5) quiet_phase = 1'b1;

         // Mostly well-formed link traffic with random content, plus noise.
         for (n = 0; n < 100; n++) begin
            q.op       = OP_FRAME;
            q.frame_id = $urandom;
            q.b0       = $urandom;
            q.b1       = $urandom;
            q.b2       = $urandom;
            q.b3       = $urandom;
            q.slot     = $urandom;
            w = $urandom_range(0, 99);
            if (w < 20) begin
               q.op = OP_TICK;
            end else if (w < 32) begin
               q.frame_id = cfg.reply_id;
               q.b0 = B_SYNC_OK0;
               q.b1 = B_SYNC_OK1;
               if ($urandom_range(0, 1) == 0) q.b2 = B_ONE;
            end else if (w < 47) begin
               q.frame_id = cfg.reply_id;
               q.b0 = B_ALIVE;
            end else if (w < 50) begin
               q.frame_id = cfg.reply_id;
            end else if (w < 60) begin
               q.op = OP_ARM;
               q.frame_id = fid_pool[$urandom_range(0, 3)];
            end else if (w < 72) begin
               q.frame_id = fid_pool[$urandom_range(0, 3)] | cfg.mask;
               case ($urandom_range(0, 2))
                  0: q.b0 = B_ACK;
                  1: begin
                     q.b0 = B_PARTIAL0;
                     q.b1 = B_ONE;
                     q.b2 = B_ZERO;
                  end
                  default: ;
               endcase
            end else if (w < 78) begin
               q.op = OP_READ;
            end else if (w < 88) begin
               q.frame_id = cfg.key_id;
               if ($urandom_range(0, 9) != 0) begin
                  q.b0 = B_KEY0;
                  q.b1 = B_KEY1;
               end
               case ($urandom_range(0, 3))
                  0: {q.b2, q.b3} = KEY_PLAIN_A;
                  1: {q.b2, q.b3} = KEY_PLAIN_B;
                  default: ;
               endcase
            end else if (w >= 95) begin
               q.op = $urandom_range(0, 3);
            end
            pending_q.push_back(q);
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("can_display_link_handler_core verification clean");
      end else begin
         $display("can_display_link_handler_core verification failed");
      end
      $finish;
   end

endmodule
